// ----- hdl/ntr_pkg.sv -----
// shared types and constants of the nearest neighbour tile resampler
package ntr_pkg;

	localparam int COORD_W        = 15;
	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int FACTOR_W       = 4;
	localparam int DEF_MAX_DIM    = 4096;
	localparam int DEF_MAX_FACTOR = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR        = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

	typedef struct packed {
		logic [COORD_W-1:0]         base_col;
		logic [COORD_W-1:0]         base_row;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] run_max;
		logic signed [SAMPLE_W-1:0] run_min;
		logic                       up;
		logic [FACTOR_W-1:0]        factor;
	} job_t;

endpackage

// ----- hdl/ntr_if.sv -----
// channel interfaces of the nearest neighbour tile resampler
interface ntr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] elevation;
	modport source (output valid, output elevation, input ready);
	modport sink (input valid, input elevation, output ready);
endinterface

interface ntr_out_if;
	logic               valid;
	logic               ready;
	logic [14:0]        dest_col;
	logic [14:0]        dest_row;
	logic signed [15:0] sample_out;
	logic               last_of_run;
	logic signed [15:0] tile_max;
	logic signed [15:0] tile_min;
	modport source (output valid, output dest_col, output dest_row, output sample_out,
		output last_of_run, output tile_max, output tile_min, input ready);
	modport sink (input valid, input dest_col, input dest_row, input sample_out,
		input last_of_run, input tile_max, input tile_min, output ready);
endinterface

interface ntr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ntr_front.sv -----
// front end: configuration, source position tracking, sample classification and statistics
module ntr_front #(
	parameter int MAX_DIM    = ntr_pkg::DEF_MAX_DIM,
	parameter int MAX_FACTOR = ntr_pkg::DEF_MAX_FACTOR
) (
	input  logic          clk,
	input  logic          arst_n,
	ntr_cfg_if.sink       cfg,
	ntr_in_if.sink        samples,
	input  logic          job_ready,
	output logic          job_valid,
	output ntr_pkg::job_t job
);
	import ntr_pkg::*;

	localparam int DIM_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int WD    = $clog2(MAX_DIM + 1);
	localparam int CW    = (WD + 1 > 5) ? WD + 1 : 5;
	localparam int PW    = $clog2(MAX_FACTOR);

	logic [CFG_W-1:0]    width_q, height_q;
	logic                mode_q;
	logic [FACTOR_W-1:0] factor_q;

	logic [DIM_W-1:0]    col_q, row_q;
	logic [PW-1:0]       col_ph_q, row_ph_q;
	logic [COORD_W-1:0]  col_quot_q, row_quot_q;
	logic [COORD_W-1:0]  col_scl_q, row_scl_q;
	logic signed [SAMPLE_W-1:0] max_q, min_q;

	logic [WD-1:0]       w_eff, h_eff;
	logic [FACTOR_W-1:0] f_eff;
	logic                up, accept, cfg_wr, tile_start, col_last, row_last;
	logic                col_keep, row_keep, emit, col_ph_last, row_ph_last;
	logic signed [SAMPLE_W-1:0] cur_max, cur_min, new_max, new_min;

	always_comb begin
		if (width_q == '0)
			w_eff = WD'(1);
		else if (17'(width_q) > 17'(MAX_DIM))
			w_eff = WD'(MAX_DIM);
		else
			w_eff = WD'(width_q);
		if (height_q == '0)
			h_eff = WD'(1);
		else if (17'(height_q) > 17'(MAX_DIM))
			h_eff = WD'(MAX_DIM);
		else
			h_eff = WD'(height_q);
		if (factor_q == '0)
			f_eff = FACTOR_W'(1);
		else if (factor_q > FACTOR_W'(MAX_FACTOR))
			f_eff = FACTOR_W'(MAX_FACTOR);
		else
			f_eff = factor_q;
	end

	assign up          = mode_q && (f_eff != FACTOR_W'(1));
	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid;
	assign samples.ready = job_ready;
	assign accept      = samples.valid && job_ready;
	assign tile_start  = (col_q == '0) && (row_q == '0);
	assign col_last    = (CW'(col_q) + CW'(1)) >= CW'(w_eff);
	assign row_last    = (CW'(row_q) + CW'(1)) >= CW'(h_eff);
	assign col_ph_last = (FACTOR_W'(col_ph_q) + FACTOR_W'(1)) >= f_eff;
	assign row_ph_last = (FACTOR_W'(row_ph_q) + FACTOR_W'(1)) >= f_eff;
	assign col_keep    = (col_ph_q == '0) && ((CW'(col_q) + CW'(f_eff)) <= CW'(w_eff));
	assign row_keep    = (row_ph_q == '0) && ((CW'(row_q) + CW'(f_eff)) <= CW'(h_eff));
	assign emit        = up || (col_keep && row_keep);

	always_comb begin
		cur_max = tile_start ? SAMPLE_MIN : max_q;
		cur_min = tile_start ? SAMPLE_MAX : min_q;
		new_max = cur_max;
		new_min = cur_min;
		if (emit && (samples.elevation > cur_max))
			new_max = samples.elevation;
		if (emit && (samples.elevation < cur_min))
			new_min = samples.elevation;
	end

	assign job_valid    = accept && emit;
	assign job.base_col = up ? col_scl_q : col_quot_q;
	assign job.base_row = up ? row_scl_q : row_quot_q;
	assign job.sample   = samples.elevation;
	assign job.run_max  = new_max;
	assign job.run_min  = new_min;
	assign job.up       = up;
	assign job.factor   = f_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			mode_q   <= 1'b0;
			factor_q <= FACTOR_W'(1);
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_SOURCE_WIDTH:  width_q  <= cfg.data;
				REG_SOURCE_HEIGHT: height_q <= cfg.data;
				REG_MODE:          mode_q   <= cfg.data[0];
				REG_FACTOR:        factor_q <= cfg.data[FACTOR_W-1:0];
				default:           mode_q   <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			col_ph_q   <= '0;
			row_ph_q   <= '0;
			col_quot_q <= '0;
			row_quot_q <= '0;
			col_scl_q  <= '0;
			row_scl_q  <= '0;
			max_q      <= SAMPLE_MIN;
			min_q      <= SAMPLE_MAX;
		end else if (cfg_wr) begin
			col_q      <= '0;
			row_q      <= '0;
			col_ph_q   <= '0;
			row_ph_q   <= '0;
			col_quot_q <= '0;
			row_quot_q <= '0;
			col_scl_q  <= '0;
			row_scl_q  <= '0;
			max_q      <= SAMPLE_MIN;
			min_q      <= SAMPLE_MAX;
		end else if (accept) begin
			max_q <= new_max;
			min_q <= new_min;
			if (col_last) begin
				col_q      <= '0;
				col_ph_q   <= '0;
				col_quot_q <= '0;
				col_scl_q  <= '0;
				if (row_last) begin
					row_q      <= '0;
					row_ph_q   <= '0;
					row_quot_q <= '0;
					row_scl_q  <= '0;
				end else begin
					row_q     <= row_q + DIM_W'(1);
					row_scl_q <= row_scl_q + COORD_W'(f_eff);
					if (row_ph_last) begin
						row_ph_q   <= '0;
						row_quot_q <= row_quot_q + COORD_W'(1);
					end else begin
						row_ph_q <= row_ph_q + PW'(1);
					end
				end
			end else begin
				col_q     <= col_q + DIM_W'(1);
				col_scl_q <= col_scl_q + COORD_W'(f_eff);
				if (col_ph_last) begin
					col_ph_q   <= '0;
					col_quot_q <= col_quot_q + COORD_W'(1);
				end else begin
					col_ph_q <= col_ph_q + PW'(1);
				end
			end
		end
	end

endmodule

// ----- hdl/ntr_queue.sv -----
// two-entry job queue between front end and back end
module ntr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ntr_pkg::job_t push_job,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output ntr_pkg::job_t head
);
	import ntr_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = count_q != 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/ntr_back.sv -----
// back end: expands each job into its destination copies behind an output register
module ntr_back #(
	parameter int MAX_FACTOR = ntr_pkg::DEF_MAX_FACTOR
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  ntr_pkg::job_t job,
	output logic          job_pop,
	ntr_out_if.source     results
);
	import ntr_pkg::*;

	localparam int PW = $clog2(MAX_FACTOR);

	logic [PW-1:0] cx_q, cy_q;
	logic          valid_q, load, fire, cx_last, cy_last, last;

	logic [COORD_W-1:0]         col_q, row_q;
	logic signed [SAMPLE_W-1:0] sample_q, max_q, min_q;
	logic                       last_q;

	assign load    = !valid_q || results.ready;
	assign fire    = load && job_valid;
	assign cx_last = (FACTOR_W'(cx_q) + FACTOR_W'(1)) >= job.factor;
	assign cy_last = (FACTOR_W'(cy_q) + FACTOR_W'(1)) >= job.factor;
	assign last    = !job.up || (cx_last && cy_last);
	assign job_pop = fire && last;

	assign results.valid       = valid_q;
	assign results.dest_col    = col_q;
	assign results.dest_row    = row_q;
	assign results.sample_out  = sample_q;
	assign results.last_of_run = last_q;
	assign results.tile_max    = max_q;
	assign results.tile_min    = min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
		end else begin
			if (load)
				valid_q <= job_valid;
			if (fire) begin
				if (last) begin
					cx_q <= '0;
					cy_q <= '0;
				end else if (cx_last) begin
					cx_q <= '0;
					cy_q <= cy_q + PW'(1);
				end else begin
					cx_q <= cx_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			col_q    <= job.base_col + COORD_W'(cx_q);
			row_q    <= job.base_row + COORD_W'(cy_q);
			sample_q <= job.sample;
			max_q    <= job.run_max;
			min_q    <= job.run_min;
			last_q   <= last;
		end
	end

endmodule

// ----- hdl/nearest_neighbour_tile_resampler.sv -----
// top level of the nearest neighbour tile resampler
// usage:
// - cfg: register writes (source_width, source_height, mode, factor); always ready,
//   write only while idle; every write restarts the tile at position (0,0)
// - samples: one signed elevation per transaction, tile in raster order
// - results: destination column, row, sample, last_of_run and running max/min
// - shrink mode gives zero or one result per sample, enlarge mode factor squared
// - path: a taken sample's job is written into the job queue, and its result then
//   leaves through the output register
// - throughput: one sample per cycle in shrink mode or with factor one, while the
//   receiver is ready; in enlarge mode the back end emits one copy per cycle while
//   the receiver is ready, and the queue can take further samples meanwhile
// - a two-entry job queue sits between the position tracker and the copy
//   generator; samples are taken while the queue has room
// - a stalled receiver holds the output register; the queue then fills and
//   samples ready drops
// - reset: 1 by 1 tile, shrink mode, factor one, position (0,0), queue empty
module nearest_neighbour_tile_resampler #(
	parameter int MAX_DIM    = ntr_pkg::DEF_MAX_DIM,
	parameter int MAX_FACTOR = ntr_pkg::DEF_MAX_FACTOR
) (
	input logic       clk,
	input logic       arst_n,
	ntr_cfg_if.sink   cfg,
	ntr_in_if.sink    samples,
	ntr_out_if.source results
);
	import ntr_pkg::*;

	job_t front_job, head_job;
	logic front_valid, q_not_full, q_not_empty, q_pop;

	ntr_front #(
		.MAX_DIM    (MAX_DIM),
		.MAX_FACTOR (MAX_FACTOR)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.samples   (samples),
		.job_ready (q_not_full),
		.job_valid (front_valid),
		.job       (front_job)
	);

	ntr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_job  (front_job),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	ntr_back #(
		.MAX_FACTOR (MAX_FACTOR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (head_job),
		.job_pop   (q_pop),
		.results   (results)
	);

endmodule
